@@ hw/rtl/srb_pkg.sv @@
// Shared types and constants for the SPI register bank target.
// Used by srb_bank, spi_register_bank_slave_unit, srb_scoreboard_pkg and the testbench; depends on nothing.
package srb_pkg;

  localparam int BANK_DEPTH = 128;
  localparam int BANK_IDX_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int ADDR_W     = 7;
  localparam int DATA_W     = 8;
  localparam int DIR_BIT    = 7;

  localparam logic [DATA_W-1:0] HDR_XOR = 8'h55;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_SELECT = 2'd1,
    OP_FAULT  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    TX_NONE,
    TX_ZERO,
    TX_HOLD,
    TX_LOAD,
    TX_TOGGLE
  } tx_act_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } bank_req_t;

  function automatic logic in_bank(input logic [ADDR_W-1:0] addr);
    in_bank = (int'(addr) < BANK_DEPTH);
  endfunction

endpackage

@@ hw/rtl/srb_bank.sv @@
// Register bank storage: one write and one registered read port per cycle.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses srb_pkg.
module srb_bank (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  srb_pkg::bank_req_t               req_i,
  output logic [srb_pkg::DATA_W-1:0]       rdata_o
);

  logic [srb_pkg::DATA_W-1:0]     mem_q [srb_pkg::BANK_DEPTH];
  logic [srb_pkg::BANK_DEPTH-1:0] vld_q;
  logic [srb_pkg::DATA_W-1:0]     rdata_q;
  logic                           rok_q;
  logic [srb_pkg::BANK_IDX_W-1:0] widx;
  logic [srb_pkg::BANK_IDX_W-1:0] ridx;
  logic                           wr_en;

  assign widx  = req_i.waddr[srb_pkg::BANK_IDX_W-1:0];
  assign ridx  = req_i.raddr[srb_pkg::BANK_IDX_W-1:0];
  assign wr_en = req_i.we && srb_pkg::in_bank(req_i.waddr);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[widx] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[ridx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rok_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[widx] <= 1'b1;
      end
      if (req_i.re) begin
        rok_q <= vld_q[ridx] && srb_pkg::in_bank(req_i.raddr);
      end
    end
  end

  assign rdata_o = rok_q ? rdata_q : '0;

endmodule

@@ hw/rtl/spi_register_bank_slave_unit.sv @@
// SPI register bank target, top level: packet decode, bank access and result register.
// Uses srb_pkg and srb_bank.
//
// Usage: the input channel takes one SPI event per beat (operation_i: byte
// received, select or fault; rx_byte_i with the byte). Every accepted beat
// gives exactly one result beat on the output channel: the byte loaded for
// transmission, the bank write that happened, and the header check flag.
// Timing: an accepted beat is held in the middle stage, then in the result
// register on out_valid_o. A fetch's bank read is issued on acceptance and its
// data registered; the transmit value is formed and registered on leaving that stage.
// Throughput: one beat per cycle while out_stall_i holds no result, set by the
// single bank read port and the two-stage pipeline behind it.
// Stalls: when out_stall_i holds a result, the middle stage fills, then
// in_stall_o rises in the same cycle; payload and read data hold meanwhile.
// Reset: packet state and transmit value clear; the bank reads as all zero
// through per-entry valid bits, so no clearing pass is needed and the block
// accepts beats as soon as reset is released.
module spi_register_bank_slave_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         tx_valid_o,
  output logic [7:0]                   tx_byte_o,
  output logic                         write_valid_o,
  output logic [6:0]                   write_address_o,
  output logic [7:0]                   write_data_o,
  output logic                         header_bad_o
);

  // packet state
  logic [1:0]                   pos_q, pos_d;
  logic                         parity_q, parity_d;
  logic [srb_pkg::DATA_W-1:0]   first_q, first_d;
  logic                         is_write_q, is_write_d;
  logic                         bad_q, bad_d;
  logic [srb_pkg::ADDR_W-1:0]   addr_q, addr_d;
  logic [srb_pkg::DATA_W-1:0]   tx_hold_q, tx_hold_d;

  // middle stage
  logic                         s1_vld_q;
  srb_pkg::tx_act_e             s1_act_q, s1_act_d;
  logic                         s1_wv_q, s1_wv_d;
  logic [srb_pkg::ADDR_W-1:0]   s1_wa_q, s1_wa_d;
  logic [srb_pkg::DATA_W-1:0]   s1_wd_q, s1_wd_d;
  logic                         s1_hb_q, s1_hb_d;

  // result register
  logic                         out_vld_q;
  logic                         tx_valid_q;
  logic [srb_pkg::DATA_W-1:0]   tx_byte_q, tx_byte_d;
  logic                         wv_q;
  logic [srb_pkg::ADDR_W-1:0]   wa_q;
  logic [srb_pkg::DATA_W-1:0]   wd_q;
  logic                         hb_q;

  logic                         s1_adv;
  logic                         in_acc;
  srb_pkg::bank_req_t           breq;
  logic [srb_pkg::DATA_W-1:0]   rdata;

  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  srb_bank u_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (breq),
    .rdata_o (rdata)
  );

  always_comb begin
    pos_d      = pos_q;
    parity_d   = parity_q;
    first_d    = first_q;
    is_write_d = is_write_q;
    bad_d      = bad_q;
    addr_d     = addr_q;
    s1_act_d   = srb_pkg::TX_NONE;
    s1_wv_d    = 1'b0;
    s1_wa_d    = '0;
    s1_wd_d    = '0;
    s1_hb_d    = 1'b0;
    breq       = '0;
    breq.waddr = addr_q;
    breq.wdata = rx_byte_i;
    case (operation_i)
      srb_pkg::OP_SELECT, srb_pkg::OP_FAULT: begin
        pos_d    = 2'd0;
        parity_d = 1'b0;
        s1_act_d = srb_pkg::TX_ZERO;
      end
      srb_pkg::OP_BYTE: begin
        s1_act_d = srb_pkg::TX_HOLD;
        case (pos_q)
          2'd0: begin
            first_d    = rx_byte_i;
            is_write_d = rx_byte_i[srb_pkg::DIR_BIT];
          end
          2'd1: begin
            bad_d   = (rx_byte_i ^ srb_pkg::HDR_XOR) != first_q;
            s1_hb_d = bad_d;
            addr_d  = first_q[srb_pkg::ADDR_W-1:0];
            if (!bad_d && !is_write_q) begin
              breq.re    = 1'b1;
              breq.raddr = first_q[srb_pkg::ADDR_W-1:0];
              addr_d     = first_q[srb_pkg::ADDR_W-1:0] + 7'd1;
              s1_act_d   = srb_pkg::TX_LOAD;
            end
          end
          default: begin
            if (!bad_q) begin
              if (is_write_q) begin
                if (srb_pkg::in_bank(addr_q)) begin
                  breq.we = 1'b1;
                  s1_wv_d = 1'b1;
                  s1_wa_d = addr_q;
                  s1_wd_d = rx_byte_i;
                end
                addr_d = addr_q + 7'd1;
              end else if (parity_q) begin
                breq.re    = 1'b1;
                breq.raddr = addr_q;
                addr_d     = addr_q + 7'd1;
                s1_act_d   = srb_pkg::TX_LOAD;
              end else begin
                s1_act_d = srb_pkg::TX_TOGGLE;
              end
            end
          end
        endcase
        if (pos_q != 2'd2) begin
          pos_d = pos_q + 2'd1;
        end
        parity_d = !parity_q;
      end
      default: begin
      end
    endcase
    if (!in_acc) begin
      breq.we = 1'b0;
      breq.re = 1'b0;
    end
  end

  always_comb begin
    tx_hold_d = tx_hold_q;
    case (s1_act_q)
      srb_pkg::TX_LOAD:   tx_hold_d = rdata;
      srb_pkg::TX_TOGGLE: tx_hold_d = tx_hold_q ^ srb_pkg::HDR_XOR;
      default:            tx_hold_d = tx_hold_q;
    endcase
    tx_byte_d = (s1_act_q == srb_pkg::TX_NONE || s1_act_q == srb_pkg::TX_ZERO) ?
                '0 : tx_hold_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 2'd0;
      parity_q   <= 1'b0;
      first_q    <= '0;
      is_write_q <= 1'b0;
      bad_q      <= 1'b0;
      addr_q     <= '0;
      tx_hold_q  <= '0;
      s1_vld_q   <= 1'b0;
      s1_act_q   <= srb_pkg::TX_NONE;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        pos_q      <= pos_d;
        parity_q   <= parity_d;
        first_q    <= first_d;
        is_write_q <= is_write_d;
        bad_q      <= bad_d;
        addr_q     <= addr_d;
        s1_act_q   <= s1_act_d;
      end
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        tx_hold_q <= tx_hold_d;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_wv_q <= s1_wv_d;
      s1_wa_q <= s1_wa_d;
      s1_wd_q <= s1_wd_d;
      s1_hb_q <= s1_hb_d;
    end
    if (s1_adv) begin
      tx_valid_q <= (s1_act_q != srb_pkg::TX_NONE);
      tx_byte_q  <= tx_byte_d;
      wv_q       <= s1_wv_q;
      wa_q       <= s1_wa_q;
      wd_q       <= s1_wd_q;
      hb_q       <= s1_hb_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign tx_valid_o      = tx_valid_q;
  assign tx_byte_o       = tx_byte_q;
  assign write_valid_o   = wv_q;
  assign write_address_o = wa_q;
  assign write_data_o    = wd_q;
  assign header_bad_o    = hb_q;

endmodule

@@ hw/rtl/srb_checker.sv @@
// Port-level checks for spi_register_bank_slave_unit, attached by bind.
// Sees only the top-level ports; uses no package.
module srb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] operation_i,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       tx_valid_o,
  input logic [7:0] tx_byte_o,
  input logic       write_valid_o,
  input logic [6:0] write_address_o,
  input logic [7:0] write_data_o,
  input logic       header_bad_o
);

  // a stalled result beat stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tx_byte_o)
      && $stable(write_valid_o) && $stable(write_address_o) && $stable(write_data_o))
    else $error("result beat changed while stalled");

  // a bank write only comes with a transmitted byte and a good header
  a_write_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |-> tx_valid_o && !header_bad_o)
    else $error("write beat without tx or with bad header");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> write_address_o == 7'd0 && write_data_o == 8'd0)
    else $error("write fields set without a write");

  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> tx_byte_o == 8'd0 && !header_bad_o)
    else $error("ignored beat carries data");

  // with the output free, the input never stalls
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !$past(out_valid_o) |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind spi_register_bank_slave_unit srb_checker u_srb_checker (.*);

@@ verif/srb_scoreboard_pkg.sv @@
// Scoreboard for the SPI register bank target: a predictor of every result beat
// and the queue of results still owed by the block. Depends on srb_pkg.
package srb_scoreboard_pkg;

  typedef struct packed {
    logic                       tx_valid;
    logic [srb_pkg::DATA_W-1:0] tx_byte;
    logic                       write_valid;
    logic [srb_pkg::ADDR_W-1:0] write_address;
    logic [srb_pkg::DATA_W-1:0] write_data;
    logic                       header_bad;
  } srb_result_t;

  class spi_bank_scoreboard;
    logic [1:0]                 byte_pos;
    logic                       odd_byte;
    logic [srb_pkg::DATA_W-1:0] hdr_byte;
    logic                       wr_packet;
    logic                       bad_packet;
    logic [srb_pkg::ADDR_W-1:0] next_reg;
    logic [srb_pkg::DATA_W-1:0] tx_value;
    logic [srb_pkg::DATA_W-1:0] bank_image [srb_pkg::BANK_DEPTH];
    srb_result_t                owed_results [$];
    int                         beats_noted;
    int                         results_checked;
    int                         writes_seen;
    int                         headers_bad;
    int                         restarts;
    int                         mismatches;

    function new();
      byte_pos        = '0;
      odd_byte        = 1'b0;
      hdr_byte        = '0;
      wr_packet       = 1'b0;
      bad_packet      = 1'b0;
      next_reg        = '0;
      tx_value        = '0;
      beats_noted     = 0;
      results_checked = 0;
      writes_seen     = 0;
      headers_bad     = 0;
      restarts        = 0;
      mismatches      = 0;
      foreach (bank_image[i]) bank_image[i] = '0;
    endfunction

    function logic [srb_pkg::DATA_W-1:0] fetch_register();
      logic [srb_pkg::DATA_W-1:0] v;
      v = (int'(next_reg) < srb_pkg::BANK_DEPTH) ? bank_image[next_reg] : '0;
      next_reg = next_reg + 7'd1;
      return v;
    endfunction

    function srb_result_t predict_response(input logic [1:0] op, input logic [7:0] rx);
      srb_result_t r;
      r = '0;
      if (op == srb_pkg::OP_SELECT || op == srb_pkg::OP_FAULT) begin
        byte_pos   = '0;
        odd_byte   = 1'b0;
        r.tx_valid = 1'b1;
        restarts++;
        return r;
      end
      if (op != srb_pkg::OP_BYTE) return r;

      if (byte_pos == 2'd0) begin
        hdr_byte  = rx;
        wr_packet = rx[srb_pkg::DIR_BIT];
      end else if (byte_pos == 2'd1) begin
        bad_packet   = ((rx ^ srb_pkg::HDR_XOR) != hdr_byte);
        r.header_bad = bad_packet;
        if (bad_packet) headers_bad++;
        next_reg = hdr_byte[srb_pkg::ADDR_W-1:0];
        if (!bad_packet && !wr_packet) tx_value = fetch_register();
      end else if (!bad_packet) begin
        if (wr_packet) begin
          if (int'(next_reg) < srb_pkg::BANK_DEPTH) begin
            bank_image[next_reg] = rx;
            r.write_valid   = 1'b1;
            r.write_address = next_reg;
            r.write_data    = rx;
            writes_seen++;
          end
          next_reg = next_reg + 7'd1;
        end else if (odd_byte) begin
          tx_value = fetch_register();
        end else begin
          tx_value = tx_value ^ srb_pkg::HDR_XOR;
        end
      end

      if (byte_pos != 2'd2) byte_pos = byte_pos + 2'd1;
      odd_byte   = ~odd_byte;
      r.tx_valid = 1'b1;
      r.tx_byte  = tx_value;
      return r;
    endfunction

    function void note_beat(input logic [1:0] op, input logic [7:0] rx);
      owed_results.push_back(predict_response(op, rx));
      beats_noted++;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    task report(input string what, input int unsigned got, input int unsigned want);
      mismatches++;
      if (mismatches <= 40)
        $display("MISMATCH at result %0d: %s got 0x%0h want 0x%0h",
                 results_checked, what, got, want);
    endtask

    task check_result(input srb_result_t got);
      srb_result_t want;
      if (owed_results.size() == 0) begin
        report("unexpected result beat", 32'(got), 0);
        return;
      end
      want = owed_results.pop_front();
      if (got.tx_valid !== want.tx_valid)
        report("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
      if (got.write_valid !== want.write_valid)
        report("write_valid", 32'(got.write_valid), 32'(want.write_valid));
      if (got.write_address !== want.write_address)
        report("write_address", 32'(got.write_address), 32'(want.write_address));
      if (got.write_data !== want.write_data)
        report("write_data", 32'(got.write_data), 32'(want.write_data));
      if (got.header_bad !== want.header_bad)
        report("header_bad", 32'(got.header_bad), 32'(want.header_bad));
      results_checked++;
    endtask
  endclass

endpackage

@@ verif/spi_register_bank_slave_unit_test.sv @@
// Testbench for spi_register_bank_slave_unit: directed and random SPI packets with
// random gaps and stalls on both channels, checked beat by beat.
// Depends on srb_pkg and srb_scoreboard_pkg.
module spi_register_bank_slave_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS      = 750;
  localparam int HOLD_OFF   = 300;
  localparam int IDLE_LIMIT = 4000;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic [1:0] operation_i     = srb_pkg::OP_BYTE;
  logic [7:0] rx_byte_i       = 8'h00;
  logic       out_stall_i     = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       tx_valid_o;
  logic [7:0] tx_byte_o;
  logic       write_valid_o;
  logic [6:0] write_address_o;
  logic [7:0] write_data_o;
  logic       header_bad_o;

  srb_scoreboard_pkg::spi_bank_scoreboard board = new();
  bit hold_off_req = 1'b0;
  bit no_gaps      = 1'b0;
  int beats_sent   = 0;

  spi_register_bank_slave_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .tx_valid_o      (tx_valid_o),
    .tx_byte_o       (tx_byte_o),
    .write_valid_o   (write_valid_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .header_bad_o    (header_bad_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic send_beat(input logic [1:0] op, input logic [7:0] rx);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    rx_byte_i   <= rx;
    do @(posedge clk_i); while (in_stall_o);
    board.note_beat(op, rx);
    beats_sent++;
  endtask

  task automatic pause();
    int g;
    g = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3)) :
                                     int'($urandom_range(10, 30));
    if (g > 0 && !no_gaps) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic beat(input logic [1:0] op, input logic [7:0] rx);
    send_beat(op, rx);
    pause();
  endtask

  task automatic send_packet(input bit wr, input logic [6:0] addr, input int n_data,
                             input bit corrupt_check, input bit with_select);
    logic [7:0] hdr;
    logic [7:0] chk;
    hdr = {wr, addr};
    chk = hdr ^ srb_pkg::HDR_XOR;
    if (corrupt_check) chk = chk ^ (8'h01 << $urandom_range(0, 7));
    if (with_select) beat(srb_pkg::OP_SELECT, 8'($urandom));
    beat(srb_pkg::OP_BYTE, hdr);
    beat(srb_pkg::OP_BYTE, chk);
    repeat (n_data) beat(srb_pkg::OP_BYTE, 8'($urandom));
  endtask

  // result side
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result({tx_valid_o, tx_byte_o, write_valid_o, write_address_o,
                          write_data_o, header_bad_o});
  end

  initial begin
    int n;
    int m;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        n = ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3)) :
                                         int'($urandom_range(10, 40));
        m = ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 6)) :
                                         int'($urandom_range(30, 80));
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat (m) @(posedge clk_i);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int pick;
    int n;
    bit pressure_done;
    logic [6:0] addr;
    pressure_done = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: write across the top of the bank, read back with wrap
    beat(srb_pkg::OP_SELECT, 8'h00);
    beat(srb_pkg::OP_BYTE, 8'hFE);
    beat(srb_pkg::OP_BYTE, 8'hFE ^ srb_pkg::HDR_XOR);
    beat(srb_pkg::OP_BYTE, 8'hFF);
    beat(srb_pkg::OP_BYTE, 8'h00);
    beat(srb_pkg::OP_BYTE, 8'hA5);
    send_packet(1'b0, 7'h7E, 6, 1'b0, 1'b1);
    beat(srb_pkg::OP_FAULT, 8'hFF);
    beat(OP_UNUSED, 8'hFF);
    beat(srb_pkg::OP_BYTE, 8'h00);
    beat(srb_pkg::OP_BYTE, 8'h00);
    beat(srb_pkg::OP_BYTE, 8'h3C);
    send_packet(1'b1, 7'h00, 2, 1'b1, 1'b1);
    send_packet(1'b0, 7'h00, 3, 1'b0, 1'b0);

    while (beats_sent < ITEMS) begin
      if (!pressure_done && beats_sent > 300) begin
        pressure_done = 1'b1;
        hold_off_req  = 1'b1;
        no_gaps       = 1'b1;
        repeat (24) beat(srb_pkg::OP_BYTE, 8'($urandom));
        no_gaps       = 1'b0;
      end
      pick = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 9) == 0);
      addr = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(0, 15) - 8) : 7'($urandom);
      n = ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 6)) :
                                       int'($urandom_range(10, 20));
      if (pick < 70) begin
        send_packet(1'($urandom_range(0, 1)), addr, n, 1'b0, 1'b1);
      end else if (pick < 80) begin
        send_packet(1'($urandom_range(0, 1)), addr, n, 1'b1, 1'b1);
      end else if (pick < 90) begin
        beat(2'($urandom_range(0, 3)), 8'($urandom));
      end else if (pick < 95) begin
        send_packet(1'($urandom_range(0, 1)), addr, int'($urandom_range(0, 3)), 1'b0, 1'b1);
        beat(srb_pkg::OP_FAULT, 8'($urandom));
      end else begin
        send_packet(1'($urandom_range(0, 1)), addr, n, 1'b0, 1'b0);
      end
      no_gaps = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Drove %0d beats, checked %0d results: %0d bank writes,",
             board.beats_noted, board.results_checked, board.writes_seen);
    $display("%0d bad headers, %0d restarts, with long output hold-off and input stalls",
             board.headers_bad, board.restarts);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
